// ===== src/psr_pkg.sv =====
// Package for the pinch scale and rotation unit: shared widths, CORDIC angle table,
// Q30 angle constants and the flag struct passed from the scale lane.
// No dependencies.
package psr_pkg;

  localparam int ZW = 35;
  localparam int SCALE_W = 24;
  localparam int ROT_W = 16;
  localparam int QW = 48;
  localparam int ROOT_W = 24;
  localparam int TAB_LEN = 24;

  localparam logic signed [ZW-1:0] Q30_PI = 35'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [ZW-1:0] Q30_TWO_PI = 35'sd6746518852;
  localparam logic [SCALE_W-1:0] SCALE_MAX = 24'hFFFFFF;

  localparam logic [31:0] ATAN_Q30 [TAB_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic bz;
    logic clip;
  } psr_flags_t;

endpackage

// ===== src/psr_if.sv =====
// Channel interfaces of the pinch scale and rotation unit: input beat of touch
// coordinates and output beat of scale and rotation. Depends on nothing.
interface psr_in_if #(parameter int COORD_BITS = 12);
  logic valid;
  logic ready;
  logic [COORD_BITS-1:0] cur_ax;
  logic [COORD_BITS-1:0] cur_ay;
  logic [COORD_BITS-1:0] cur_bx;
  logic [COORD_BITS-1:0] cur_by;
  logic [COORD_BITS-1:0] prev_ax;
  logic [COORD_BITS-1:0] prev_ay;
  logic [COORD_BITS-1:0] prev_bx;
  logic [COORD_BITS-1:0] prev_by;
  modport source (output valid, cur_ax, cur_ay, cur_bx, cur_by,
                  prev_ax, prev_ay, prev_bx, prev_by, input ready);
  modport sink (input valid, cur_ax, cur_ay, cur_bx, cur_by,
                prev_ax, prev_ay, prev_bx, prev_by, output ready);
endinterface

interface psr_out_if;
  logic valid;
  logic ready;
  logic [23:0] scale_factor;
  logic signed [15:0] rotation_delta;
  logic base_zero;
  logic scale_clipped;
  modport source (output valid, scale_factor, rotation_delta, base_zero, scale_clipped,
                  input ready);
  modport sink (input valid, scale_factor, rotation_delta, base_zero, scale_clipped,
                output ready);
endinterface

// ===== src/psr_cordic_lane.sv =====
// Angle lane: pipelined vectoring CORDIC giving atan2 in Q30, then a delay line
// to line up with the scale lane. Depends on psr_pkg.
module psr_cordic_lane #(
  parameter int CB = 12,
  parameter int STEPS = 16,
  parameter int PAD = 57
) (
  input  logic clk,
  input  logic en,
  input  logic signed [CB:0] dx,
  input  logic signed [CB:0] dy,
  output logic signed [psr_pkg::ZW-1:0] z
);
  import psr_pkg::*;

  localparam int XW = CB + 27;

  logic signed [XW-1:0] xi, yi;
  logic signed [XW-1:0] x [0:STEPS];
  logic signed [XW-1:0] y [0:STEPS];
  logic signed [ZW-1:0] za [0:STEPS];
  logic nz [0:STEPS];
  logic signed [ZW-1:0] pd [0:PAD];

  assign xi = XW'(dx) <<< 24;
  assign yi = XW'(dy) <<< 24;

  always_ff @(posedge clk) begin
    if (en) begin
      nz[0] <= (dx != '0) || (dy != '0);
      if (xi < 0) begin
        if (yi >= 0) begin
          x[0] <= yi;
          y[0] <= -xi;
          za[0] <= Q30_HALF_PI;
        end else begin
          x[0] <= -yi;
          y[0] <= xi;
          za[0] <= -Q30_HALF_PI;
        end
      end else begin
        x[0] <= xi;
        y[0] <= yi;
        za[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = $signed({3'b000, ATAN_Q30[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        nz[i+1] <= nz[i];
        if (y[i] >= 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          za[i+1] <= za[i] + ANG;
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          za[i+1] <= za[i] - ANG;
        end
      end
    end
  end

  assign pd[0] = nz[STEPS] ? za[STEPS] : '0;

  for (genvar k = 0; k < PAD; k++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        pd[k+1] <= pd[k];
      end
    end
  end

  assign z = pd[PAD];

endmodule

// ===== src/psr_scale_lane.sv =====
// Scale lane: pipelined restoring divider for C*2^(2F)/P, then a pipelined
// digit-by-digit square root; carries the zero-base and clip flags. Depends on psr_pkg.
module psr_scale_lane #(
  parameter int PW = 25,
  parameter int F = 16
) (
  input  logic clk,
  input  logic en,
  input  logic [PW-1:0] c2,
  input  logic [PW-1:0] p2,
  output logic [psr_pkg::ROOT_W-1:0] root,
  output psr_pkg::psr_flags_t flags
);
  import psr_pkg::*;

  localparam int NX = (PW + 2 * F > QW) ? PW + 2 * F : QW + 1;
  localparam int HW = NX - QW;
  localparam int CW = (HW > PW) ? HW : PW;
  localparam int RW = PW + 1;
  localparam int NST = 1 + QW + ROOT_W;

  logic [NX-1:0] n;
  logic [HW-1:0] hi;
  logic [RW-1:0] rem [0:QW];
  logic [QW-1:0] qn [0:QW];
  logic [PW-1:0] dv [0:QW];
  logic [QW-1:0] sq [0:ROOT_W];
  logic [26:0] sr [0:ROOT_W];
  logic [ROOT_W-1:0] rt [0:ROOT_W];
  psr_flags_t fl [0:NST-1];

  assign n = NX'(c2) << (2 * F);
  assign hi = n[NX-1:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0].bz <= (p2 == '0);
      fl[0].clip <= (p2 != '0) && (CW'(hi) >= CW'(p2));
      rem[0] <= RW'(hi);
      qn[0] <= n[QW-1:0];
      dv[0] <= p2;
    end
  end

  for (genvar k = 0; k < NST - 1; k++) begin : g_flag
    always_ff @(posedge clk) begin
      if (en) begin
        fl[k+1] <= fl[k];
      end
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [RW-1:0] sh;
    assign sh = {rem[i][RW-2:0], qn[i][QW-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        dv[i+1] <= dv[i];
        if (sh >= RW'(dv[i])) begin
          rem[i+1] <= sh - RW'(dv[i]);
          qn[i+1] <= {qn[i][QW-2:0], 1'b1};
        end else begin
          rem[i+1] <= sh;
          qn[i+1] <= {qn[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign sq[0] = qn[QW];
  assign sr[0] = '0;
  assign rt[0] = '0;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    logic [26:0] t, trial;
    assign t = {sr[j][24:0], sq[j][QW-1:QW-2]};
    assign trial = {1'b0, rt[j], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        sq[j+1] <= {sq[j][QW-3:0], 2'b00};
        if (t >= trial) begin
          sr[j+1] <= t - trial;
          rt[j+1] <= {rt[j][ROOT_W-2:0], 1'b1};
        end else begin
          sr[j+1] <= t;
          rt[j+1] <= {rt[j][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root = rt[ROOT_W];
  assign flags = fl[NST-1];

endmodule

// ===== src/pinch_scale_rotation_unit.sv =====
// Pinch scale and rotation unit: one frame per cycle unless the output is held;
// the depth is set by the scale lane (48 divider stages and 24 square-root stages)
// that the two CORDIC angle lanes are delayed to match. The whole pipeline holds
// while a result waits at the output. Depends on psr_pkg and psr_if.
module pinch_scale_rotation_unit #(
  parameter int COORD_BITS = 12,
  parameter int SCALE_FRAC_BITS = 16,
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int CORDIC_STEPS = 16
) (
  input logic clk,
  input logic rst,
  psr_in_if.sink in_ch,
  psr_out_if.source out_ch
);
  import psr_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PW = 2 * CB + 1;
  localparam int LAT = 77;
  localparam int PAD = 73 - CORDIC_STEPS;
  localparam int K = 30 - ANGLE_FRAC_BITS;
  localparam logic [SCALE_W:0] ONE_W = (SCALE_W + 1)'(1) << SCALE_FRAC_BITS;
  localparam logic [SCALE_W-1:0] ONE =
    (ONE_W > {1'b0, SCALE_MAX}) ? SCALE_MAX : ONE_W[SCALE_W-1:0];
  localparam logic signed [ZW-1:0] HALF = ZW'(1) <<< (K - 1);

  logic en;
  logic [LAT-1:0] vld;
  logic signed [CB:0] cdx, cdy, pdx, pdy;
  logic signed [2*CB+1:0] sq_cx, sq_cy, sq_px, sq_py;
  logic [PW-1:0] c2, p2;
  logic [ROOT_W-1:0] root;
  psr_flags_t flags;
  logic signed [ZW-1:0] zc, zp, d, dw, rs;
  logic [SCALE_W-1:0] scl1;
  logic bz1, cl1;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cdx <= $signed({1'b0, in_ch.cur_bx}) - $signed({1'b0, in_ch.cur_ax});
      cdy <= $signed({1'b0, in_ch.cur_by}) - $signed({1'b0, in_ch.cur_ay});
      pdx <= $signed({1'b0, in_ch.prev_bx}) - $signed({1'b0, in_ch.prev_ax});
      pdy <= $signed({1'b0, in_ch.prev_by}) - $signed({1'b0, in_ch.prev_ay});
    end
  end

  assign sq_cx = cdx * cdx;
  assign sq_cy = cdy * cdy;
  assign sq_px = pdx * pdx;
  assign sq_py = pdy * pdy;

  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= PW'($unsigned(sq_cx) + $unsigned(sq_cy));
      p2 <= PW'($unsigned(sq_px) + $unsigned(sq_py));
    end
  end

  psr_scale_lane #(.PW(PW), .F(SCALE_FRAC_BITS)) u_scale (
    .clk(clk), .en(en), .c2(c2), .p2(p2), .root(root), .flags(flags)
  );

  psr_cordic_lane #(.CB(CB), .STEPS(CORDIC_STEPS), .PAD(PAD)) u_ang_cur (
    .clk(clk), .en(en), .dx(cdx), .dy(cdy), .z(zc)
  );

  psr_cordic_lane #(.CB(CB), .STEPS(CORDIC_STEPS), .PAD(PAD)) u_ang_prev (
    .clk(clk), .en(en), .dx(pdx), .dy(pdy), .z(zp)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d <= zc - zp;
      bz1 <= flags.bz;
      cl1 <= flags.clip && !flags.bz;
      if (flags.bz) begin
        scl1 <= ONE;
      end else if (flags.clip) begin
        scl1 <= SCALE_MAX;
      end else begin
        scl1 <= root;
      end
    end
  end

  always_comb begin
    if (d > Q30_PI) begin
      dw = d - Q30_TWO_PI;
    end else if (d <= -Q30_PI) begin
      dw = d + Q30_TWO_PI;
    end else begin
      dw = d;
    end
    rs = (dw + HALF) >>> K;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.scale_factor <= scl1;
      out_ch.base_zero <= bz1;
      out_ch.scale_clipped <= cl1;
      if (rs > ZW'(32767)) begin
        out_ch.rotation_delta <= 16'sh7FFF;
      end else if (rs < -ZW'(32768)) begin
        out_ch.rotation_delta <= -16'sh8000;
      end else begin
        out_ch.rotation_delta <= rs[ROT_W-1:0];
      end
    end
  end

  assign out_ch.valid = vld[LAT-1];

  a_base_zero : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.base_zero |-> !out_ch.scale_clipped && out_ch.scale_factor == ONE)
    else $error("base_zero beat without unit scale");

  a_clip : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.scale_clipped |-> out_ch.scale_factor == SCALE_MAX)
    else $error("clipped beat not saturated");

  a_hold : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline advanced while output held");

endmodule

// ===== dv/psr_tb_pkg.sv =====
`timescale 1ns / 1ps
// Beat types for the pinch scale and rotation testbench: one frame of touch
// coordinates and one scale/rotation result. Depends on psr_pkg.
package psr_tb_pkg;
  import psr_pkg::*;

  typedef struct packed {
    logic [11:0] cur_ax;
    logic [11:0] cur_ay;
    logic [11:0] cur_bx;
    logic [11:0] cur_by;
    logic [11:0] prev_ax;
    logic [11:0] prev_ay;
    logic [11:0] prev_bx;
    logic [11:0] prev_by;
  } frame_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_factor;
    logic signed [ROT_W-1:0] rotation_delta;
    logic base_zero;
    logic scale_clipped;
  } gesture_t;
endpackage

// ===== dv/pinch_scale_rotation_unit_test.sv =====
`timescale 1ns / 1ps
// Testbench of pinch_scale_rotation_unit: directed and random frames, results
// predicted in-bench and checked beat by beat. Depends on psr_pkg, psr_if, psr_tb_pkg.
module pinch_scale_rotation_unit_test;
  import psr_pkg::*;
  import psr_tb_pkg::*;

  localparam int LATENCY = 77;
  localparam int WATCHDOG = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  psr_in_if #(.COORD_BITS(12)) in_ch ();
  psr_out_if out_ch ();

  pinch_scale_rotation_unit u_top (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gesture_t gesture_q[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint finger_angle(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 64'sd16777216;
    y = dy * 64'sd16777216;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = Q30_HALF_PI;
      end else begin
        x = -y; y = t; z = -Q30_HALF_PI;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = floor_sh(x, i);
      ys = floor_sh(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += longint'(ATAN_Q30[i]);
      end else begin
        x = x - ys; y = y + xs; z -= longint'(ATAN_Q30[i]);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic gesture_t pinch_predict(frame_t f);
    gesture_t g;
    longint cdx, cdy, pdx, pdy, d, rnd;
    longint unsigned c2, p2, q, r, s;
    cdx = longint'(f.cur_bx) - longint'(f.cur_ax);
    cdy = longint'(f.cur_by) - longint'(f.cur_ay);
    pdx = longint'(f.prev_bx) - longint'(f.prev_ax);
    pdy = longint'(f.prev_by) - longint'(f.prev_ay);
    c2 = cdx * cdx + cdy * cdy;
    p2 = pdx * pdx + pdy * pdy;
    g.base_zero = 1'b0;
    g.scale_clipped = 1'b0;
    if (p2 == 0) begin
      g.base_zero = 1'b1;
      s = 64'd1 << 16;
    end else if ((c2 >> 16) >= p2) begin
      g.scale_clipped = 1'b1;
      s = 64'hFFFFFF;
    end else begin
      q = c2 / p2;
      r = c2 % p2;
      for (int i = 0; i < 32; i++) begin
        r <<= 1; q <<= 1;
        if (r >= p2) begin
          r -= p2; q |= 1;
        end
      end
      s = root64(q);
      if (s > 64'hFFFFFF) s = 64'hFFFFFF;
    end
    g.scale_factor = s[23:0];
    d = finger_angle(cdx, cdy) - finger_angle(pdx, pdy);
    if (d > Q30_PI) d -= Q30_TWO_PI;
    else if (d <= -longint'(Q30_PI)) d += Q30_TWO_PI;
    rnd = floor_sh(d + (64'sd1 <<< 16), 17);
    if (rnd > 32767) rnd = 32767;
    if (rnd < -32768) rnd = -32768;
    g.rotation_delta = rnd[15:0];
    return g;
  endfunction

  task automatic send_frame(frame_t f);
    in_ch.valid <= 1'b1;
    {in_ch.cur_ax, in_ch.cur_ay, in_ch.cur_bx, in_ch.cur_by,
     in_ch.prev_ax, in_ch.prev_ay, in_ch.prev_bx, in_ch.prev_by} <= f;
    do @(posedge clk); while (!in_ch.ready);
    gesture_q.push_back(pinch_predict(f));
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic send_pts(int cax, int cay, int cbx, int cby,
                          int pax, int pay, int pbx, int pby);
    frame_t f;
    f = '{12'(cax), 12'(cay), 12'(cbx), 12'(cby),
          12'(pax), 12'(pay), 12'(pbx), 12'(pby)};
    send_frame(f);
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    int mode;
    f = frame_t'({$urandom, $urandom, $urandom});
    mode = $urandom_range(9);
    // hold fingers close to each other so distances and ratios vary widely
    if (mode < 4) begin
      f.cur_bx = f.cur_ax ^ 12'($urandom_range(63));
      f.cur_by = f.cur_ay ^ 12'($urandom_range(63));
      f.prev_bx = f.prev_ax ^ 12'($urandom_range(63));
      f.prev_by = f.prev_ay ^ 12'($urandom_range(63));
    end else if (mode == 4) begin
      f.prev_bx = f.prev_ax; f.prev_by = f.prev_ay;
    end else if (mode == 5) begin
      f.cur_bx = f.cur_ax; f.cur_by = f.cur_ay;
    end
    return f;
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (gesture_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_pts(0, 0, 0, 0, 0, 0, 0, 0);
    send_pts(0, 0, 4095, 4095, 0, 0, 0, 0);
    send_pts(0, 0, 4095, 4095, 0, 0, 1, 0);
    send_pts(0, 0, 1, 0, 0, 0, 4095, 4095);
    send_pts(4095, 4095, 0, 0, 0, 0, 4095, 4095);
    send_pts(4095, 0, 0, 4095, 0, 4095, 4095, 0);
    send_pts(0, 0, 0, 0, 10, 10, 20, 30);
    send_pts(0, 0, 100, 0, 0, 0, 100, 0);
    send_pts(100, 0, 0, 0, 0, 0, 100, 0);
    send_pts(0, 0, 100, 0, 100, 0, 0, 0);
    send_pts(0, 100, 0, 0, 0, 0, 0, 100);
    send_pts(0, 0, 0, 100, 0, 0, 0, 100);
    send_pts(0, 0, 4095, 1, 0, 0, 1, 0);
    send_pts(0, 0, 256, 0, 0, 0, 1, 0);
    send_pts(0, 0, 255, 0, 0, 0, 1, 0);
    send_pts(0, 0, 1, 0, 0, 0, 4095, 0);
    send_pts(5, 5, 0, 6, 5, 5, 0, 4);
    send_pts(2048, 2048, 1, 2047, 2048, 2048, 1, 2049);
  endtask

  task automatic test_random();
    frame_t f;
    for (int n = 0; n < 1000; n++) begin
      calm = (n >= 300 && n < 450);
      if (n == 600) drain();
      f = random_frame();
      send_frame(f);
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    gesture_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.scale_factor, out_ch.rotation_delta, out_ch.base_zero,
              out_ch.scale_clipped};
      if (gesture_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", got);
      end else begin
        want = gesture_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.cur_ax, in_ch.cur_ay, in_ch.cur_bx, in_ch.cur_by,
     in_ch.prev_ax, in_ch.prev_ay, in_ch.prev_bx, in_ch.prev_by} = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random();
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && gesture_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
